>>> hdl/pdc_pkg.sv
// Shared constants, input codes and the CRC-16 byte update for the packet deframer.
// No dependencies; every other file of the block imports this package.
package pdc_pkg;

  localparam logic [7:0]  START_BYTE = 8'd2;
  localparam logic [7:0]  END_BYTE   = 8'd3;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_TOP    = 16'h8000;

  localparam int TIME_W    = 32;
  localparam int CFG_W     = 20;
  localparam int OUT_POS_W = 6;

  localparam logic [CFG_W-1:0] BYTE_GAP_RESET = 20'd20000;
  localparam logic [CFG_W-1:0] POLL_GAP_RESET = 20'd50000;

  // Configuration register indexes.
  localparam logic CFG_BYTE_GAP = 1'b0;
  localparam logic CFG_POLL_GAP = 1'b1;

  // Two payload banks, so the descriptor queue between front and back is two deep.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef enum logic [1:0] {
    MODE_BYTE     = 2'd0,
    MODE_POLL     = 2'd1,
    MODE_OVERFLOW = 2'd2
  } mode_t;

  // CRC-16, polynomial 0x1021, MSB first, one byte per call.
  function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = (c << 1) ^ CRC_POLY;
      end else begin
        c = c << 1;
      end
    end
    return c;
  endfunction

endpackage

>>> hdl/pdc_front.sv
// Frame parser: takes words, checks length, CRC and trailer, writes payload bytes.
// Depends on pdc_pkg; feeds the payload memory in pdc_back and the descriptor queue.
module pdc_front
  import pdc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 40,
  parameter int LEN_W       = 6,
  parameter int POS_W       = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_mode,
  input  logic [7:0]           in_data_byte,
  input  logic [TIME_W-1:0]    in_now_us,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 q_full,
  output logic                 q_push,
  output logic                 q_bank,
  output logic [LEN_W-1:0]     q_len,
  output logic                 wr_en,
  output logic                 wr_bank,
  output logic [POS_W-1:0]     wr_pos,
  output logic [7:0]           wr_data
);

  typedef enum logic [2:0] {
    PH_HUNT   = 3'd0,
    PH_LEN    = 3'd1,
    PH_DATA   = 3'd2,
    PH_CRC_HI = 3'd3,
    PH_CRC_LO = 3'd4,
    PH_END    = 3'd5
  } phase_t;

  phase_t              phase_r, phase_nxt, phase_eff;
  logic [LEN_W-1:0]    len_r, len_nxt;
  logic [LEN_W-1:0]    fill_r, fill_nxt;
  logic [15:0]         crc_r, crc_nxt;
  logic [15:0]         rcrc_r, rcrc_nxt;
  logic [TIME_W-1:0]   last_time_r, last_time_nxt;
  logic                bank_r, bank_nxt;
  logic [CFG_W-1:0]    byte_gap_r;
  logic [CFG_W-1:0]    poll_gap_r;
  logic                accept;
  logic [TIME_W-1:0]   gap;
  logic                byte_late;
  logic                poll_late;
  logic                frame_ok;
  logic [LEN_W-1:0]    fill_inc;

  assign in_full   = q_full;
  assign accept    = in_push && !q_full;
  assign gap       = in_now_us - last_time_r;
  assign byte_late = (phase_r != PH_HUNT) && (gap > TIME_W'(byte_gap_r));
  assign poll_late = (phase_r != PH_HUNT) && (gap > TIME_W'(poll_gap_r));
  // A late byte restarts the hunt and is then parsed as if no frame were open.
  assign phase_eff = byte_late ? PH_HUNT : phase_r;
  assign frame_ok  = (in_data_byte == END_BYTE) && (rcrc_r == crc_r);
  assign fill_inc  = fill_r + LEN_W'(1);

  assign q_bank  = bank_r;
  assign q_len   = len_r;
  assign wr_bank = bank_r;
  assign wr_pos  = fill_r[POS_W-1:0];
  assign wr_data = in_data_byte;

  always_comb begin
    phase_nxt     = phase_r;
    len_nxt       = len_r;
    fill_nxt      = fill_r;
    crc_nxt       = crc_r;
    rcrc_nxt      = rcrc_r;
    last_time_nxt = last_time_r;
    bank_nxt      = bank_r;
    q_push        = 1'b0;
    wr_en         = 1'b0;
    if (accept) begin
      case (mode_t'(in_mode))
        MODE_BYTE: begin
          last_time_nxt = in_now_us;
          case (phase_eff)
            PH_HUNT: begin
              phase_nxt = (in_data_byte == START_BYTE) ? PH_LEN : PH_HUNT;
            end
            PH_LEN: begin
              if (in_data_byte == 8'd0 || in_data_byte > 8'(MAX_PAYLOAD)) begin
                phase_nxt = (in_data_byte == START_BYTE) ? PH_LEN : PH_HUNT;
              end else begin
                len_nxt   = LEN_W'(in_data_byte);
                fill_nxt  = '0;
                crc_nxt   = 16'h0000;
                phase_nxt = PH_DATA;
              end
            end
            PH_DATA: begin
              wr_en     = 1'b1;
              crc_nxt   = crc16_add_byte(crc_r, in_data_byte);
              fill_nxt  = fill_inc;
              phase_nxt = (fill_inc >= len_r) ? PH_CRC_HI : PH_DATA;
            end
            PH_CRC_HI: begin
              rcrc_nxt  = {in_data_byte, 8'h00};
              phase_nxt = PH_CRC_LO;
            end
            PH_CRC_LO: begin
              rcrc_nxt  = {rcrc_r[15:8], in_data_byte};
              phase_nxt = PH_END;
            end
            PH_END: begin
              if (frame_ok) begin
                q_push   = 1'b1;
                bank_nxt = !bank_r;
              end
              phase_nxt = (!frame_ok && in_data_byte == START_BYTE) ? PH_LEN : PH_HUNT;
            end
            default: begin
              phase_nxt = PH_HUNT;
            end
          endcase
        end
        MODE_POLL: begin
          if (poll_late) begin
            phase_nxt = PH_HUNT;
          end
        end
        MODE_OVERFLOW: begin
          phase_nxt = PH_HUNT;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    len_r  <= len_nxt;
    fill_r <= fill_nxt;
    crc_r  <= crc_nxt;
    rcrc_r <= rcrc_nxt;
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      last_time_r <= '0;
      bank_r      <= 1'b0;
      byte_gap_r  <= BYTE_GAP_RESET;
      poll_gap_r  <= POLL_GAP_RESET;
    end else begin
      phase_r     <= phase_nxt;
      last_time_r <= last_time_nxt;
      bank_r      <= bank_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_BYTE_GAP: byte_gap_r <= cfg_wdata;
          CFG_POLL_GAP: poll_gap_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> hdl/pdc_desc_fifo.sv
// Two-entry queue of good-frame descriptors (payload bank and length).
// Depends on pdc_pkg; sits between pdc_front and pdc_back.
module pdc_desc_fifo
  import pdc_pkg::*;
#(
  parameter int W = 7
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic         valid,
  output logic [W-1:0] dout
);

  logic [W-1:0]      entry_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = (count_r == (QPTR_W+1)'(QDEPTH));
  assign valid = (count_r != '0);
  assign dout  = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= din;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + (QPTR_W+1)'(1);
        2'b01:   count_r <= count_r - (QPTR_W+1)'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/pdc_back.sv
// Payload memory (two banks) and the read-out sequencer that emits result words.
// Depends on pdc_pkg; written by pdc_front, driven by the descriptor queue head.
module pdc_back
  import pdc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 40,
  parameter int LEN_W       = 6,
  parameter int POS_W       = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic                 wr_bank,
  input  logic [POS_W-1:0]     wr_pos,
  input  logic [7:0]           wr_data,
  input  logic                 head_valid,
  input  logic                 head_bank,
  input  logic [LEN_W-1:0]     head_len,
  output logic                 head_pop,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_payload_byte,
  output logic [OUT_POS_W-1:0] out_byte_position,
  output logic [OUT_POS_W-1:0] out_frame_length,
  output logic                 out_last
);

  localparam int DEPTH = 2 * MAX_PAYLOAD;
  localparam int AW    = $clog2(DEPTH);

  logic [7:0]       mem [DEPTH];
  logic [AW-1:0]    wr_addr;
  logic [AW-1:0]    rd_addr;
  logic [POS_W-1:0] rd_pos_r;
  logic             rd_en;
  logic             rd_last;
  logic             out_valid_r;
  logic [7:0]       rdata_r;
  logic [POS_W-1:0] pos_out_r;
  logic [LEN_W-1:0] len_out_r;
  logic             last_out_r;

  assign wr_addr  = wr_bank ? AW'(MAX_PAYLOAD) + AW'(wr_pos) : AW'(wr_pos);
  assign rd_addr  = head_bank ? AW'(MAX_PAYLOAD) + AW'(rd_pos_r) : AW'(rd_pos_r);
  // The read data register is the output stage, so a read goes out whenever it is free or being popped.
  assign rd_en    = head_valid && (!out_valid_r || out_pop);
  assign rd_last  = (LEN_W'(rd_pos_r) + LEN_W'(1)) == head_len;
  assign head_pop = rd_en && rd_last;

  assign out_empty         = !out_valid_r;
  assign out_payload_byte  = rdata_r;
  assign out_byte_position = OUT_POS_W'(pos_out_r);
  assign out_frame_length  = OUT_POS_W'(len_out_r);
  assign out_last          = last_out_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r    <= mem[rd_addr];
      pos_out_r  <= rd_pos_r;
      len_out_r  <= head_len;
      last_out_r <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rd_pos_r    <= '0;
    end else begin
      out_valid_r <= rd_en || (out_valid_r && !out_pop);
      if (rd_en) begin
        rd_pos_r <= rd_last ? '0 : rd_pos_r + POS_W'(1);
      end
    end
  end

endmodule

>>> hdl/packet_deframer_crc16.sv
// Start/length/payload/CRC-16/end frame receiver; one input word per cycle, in_full
// only while two good frames wait to be read out (one per payload bank).
// The first payload word passes the descriptor queue, then the read data register.
// Throughput: one word per cycle while popped, via the registered memory read port.
// Reset: synchronous active-low rst_n; no memory clearing pass.
// Depends on pdc_pkg, pdc_front, pdc_desc_fifo and pdc_back.
module packet_deframer_crc16
  import pdc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 40
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_mode,
  input  logic [7:0]           in_data_byte,
  input  logic [TIME_W-1:0]    in_now_us,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_payload_byte,
  output logic [OUT_POS_W-1:0] out_byte_position,
  output logic [OUT_POS_W-1:0] out_frame_length,
  output logic                 out_last,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int POS_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic             q_full;
  logic             q_push;
  logic             q_bank;
  logic [LEN_W-1:0] q_len;
  logic             q_valid;
  logic             q_pop;
  logic [LEN_W:0]   q_head;
  logic             wr_en;
  logic             wr_bank;
  logic [POS_W-1:0] wr_pos;
  logic [7:0]       wr_data;

  pdc_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .LEN_W      (LEN_W),
    .POS_W      (POS_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_mode     (in_mode),
    .in_data_byte(in_data_byte),
    .in_now_us   (in_now_us),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_bank      (q_bank),
    .q_len       (q_len),
    .wr_en       (wr_en),
    .wr_bank     (wr_bank),
    .wr_pos      (wr_pos),
    .wr_data     (wr_data)
  );

  pdc_desc_fifo #(
    .W(LEN_W + 1)
  ) u_queue (
    .clk  (clk),
    .rst_n(rst_n),
    .push (q_push),
    .din  ({q_bank, q_len}),
    .full (q_full),
    .pop  (q_pop),
    .valid(q_valid),
    .dout (q_head)
  );

  pdc_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .LEN_W      (LEN_W),
    .POS_W      (POS_W)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .wr_en            (wr_en),
    .wr_bank          (wr_bank),
    .wr_pos           (wr_pos),
    .wr_data          (wr_data),
    .head_valid       (q_valid),
    .head_bank        (q_head[LEN_W]),
    .head_len         (q_head[LEN_W-1:0]),
    .head_pop         (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_payload_byte (out_payload_byte),
    .out_byte_position(out_byte_position),
    .out_frame_length (out_frame_length),
    .out_last         (out_last)
  );

endmodule

>>> hdl/pdc_checker.sv
// Port-level checks for packet_deframer_crc16, attached by the bind below.
// Depends on pdc_pkg for port widths.
module pdc_checker
  import pdc_pkg::*;
#(
  parameter int MAX_PAYLOAD = 40
) (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_empty,
  input logic                 out_pop,
  input logic [7:0]           out_payload_byte,
  input logic [OUT_POS_W-1:0] out_byte_position,
  input logic [OUT_POS_W-1:0] out_frame_length,
  input logic                 out_last
);

  localparam bit FITS = (MAX_PAYLOAD < 64);

  // Nothing is offered in the cycle after a reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  // A waiting word that is not taken keeps its byte, position and last flag.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_payload_byte)
      && $stable(out_byte_position) && $stable(out_last)))
    else $error("waiting result word changed");

  // The position lies inside the frame and the last flag marks its final byte.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (FITS && !out_empty) |-> (out_byte_position < out_frame_length
      && out_last == (out_byte_position + 6'd1 == out_frame_length)))
    else $error("byte position or last flag inconsistent with frame length");

  // Within a frame the words come in order with no gap in position.
  a_in_order: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && !out_last) |=>
      (out_empty || (out_byte_position == $past(out_byte_position) + 6'd1
        && out_frame_length == $past(out_frame_length))))
    else $error("payload word skipped or repeated");

endmodule

bind packet_deframer_crc16 pdc_checker #(
  .MAX_PAYLOAD(MAX_PAYLOAD)
) u_pdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_empty        (out_empty),
  .out_pop          (out_pop),
  .out_payload_byte (out_payload_byte),
  .out_byte_position(out_byte_position),
  .out_frame_length (out_frame_length),
  .out_last         (out_last)
);

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for packet_deframer_crc16: frames, noise, polls and overflow words
// go in, payload words come out and are checked against a cycle-free frame parser model.
// Depends on pdc_pkg and the block's RTL.

import pdc_pkg::*;

localparam int MAX_LEN = 40;
localparam logic [1:0] MODE_UNUSED = 2'd3;

typedef enum logic [2:0] {
  HUNT,
  GET_LEN,
  GET_PAYLOAD,
  GET_CRC_HI,
  GET_CRC_LO,
  GET_END
} rx_phase_e;

typedef struct packed {
  logic [7:0]           payload_byte;
  logic [OUT_POS_W-1:0] byte_position;
  logic [OUT_POS_W-1:0] frame_length;
  logic                 last;
} payload_word_t;

class frame_scoreboard;
  logic [CFG_W-1:0] byte_gap_limit;
  logic [CFG_W-1:0] poll_gap_limit;
  rx_phase_e        phase;
  int               want_len;
  int               fill;
  logic [7:0]       store [MAX_LEN];
  logic [15:0]      rx_crc;
  logic [15:0]      run_crc;
  logic [31:0]      last_stamp;
  payload_word_t    payload_q [$];
  int               errors;

  function new();
    byte_gap_limit = BYTE_GAP_RESET;
    poll_gap_limit = POLL_GAP_RESET;
    last_stamp = 32'd0;
    errors = 0;
    drop();
  endfunction

  function void drop();
    phase = HUNT;
    want_len = 0;
    fill = 0;
    rx_crc = 16'h0000;
    run_crc = 16'h0000;
  endfunction

  function void set_timeout(logic idx, logic [CFG_W-1:0] value);
    if (idx == CFG_BYTE_GAP) begin
      byte_gap_limit = value;
    end else begin
      poll_gap_limit = value;
    end
  endfunction

  // Bit-serial form of the 0x1021 CRC, MSB first.
  static function logic [15:0] crc_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] r;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      if (r[15] ^ b[k]) begin
        r = {r[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        r = {r[14:0], 1'b0};
      end
    end
    return r;
  endfunction

  function int pending();
    return payload_q.size();
  endfunction

  function void take_byte(logic [7:0] b);
    payload_word_t w;
    logic ok;
    case (phase)
      HUNT: begin
        if (b == START_BYTE) phase = GET_LEN;
      end
      GET_LEN: begin
        // A start byte is always a legal length, so a bad length simply goes hunting.
        if (b == 8'd0 || b > MAX_LEN) begin
          phase = HUNT;
        end else begin
          want_len = b;
          fill = 0;
          run_crc = 16'h0000;
          phase = GET_PAYLOAD;
        end
      end
      GET_PAYLOAD: begin
        store[fill] = b;
        run_crc = crc_step(run_crc, b);
        fill++;
        if (fill >= want_len) phase = GET_CRC_HI;
      end
      GET_CRC_HI: begin
        rx_crc = {b, 8'h00};
        phase = GET_CRC_LO;
      end
      GET_CRC_LO: begin
        rx_crc[7:0] = b;
        phase = GET_END;
      end
      GET_END: begin
        ok = (b == END_BYTE) && (rx_crc == run_crc);
        if (ok) begin
          for (int i = 0; i < want_len; i++) begin
            w.payload_byte = store[i];
            w.byte_position = OUT_POS_W'(i);
            w.frame_length = OUT_POS_W'(want_len);
            w.last = (i + 1 == want_len);
            payload_q.push_back(w);
          end
        end
        phase = (!ok && b == START_BYTE) ? GET_LEN : HUNT;
      end
      default: phase = HUNT;
    endcase
  endfunction

  function void note_input(logic [1:0] mode, logic [7:0] b, logic [31:0] stamp);
    logic [31:0] gap;
    gap = stamp - last_stamp;
    case (mode)
      MODE_BYTE: begin
        if (phase != HUNT && gap > byte_gap_limit) drop();
        last_stamp = stamp;
        take_byte(b);
      end
      MODE_POLL: begin
        if (phase != HUNT && gap > poll_gap_limit) drop();
      end
      MODE_OVERFLOW: drop();
      default: ;
    endcase
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(logic [7:0] got_byte, logic [OUT_POS_W-1:0] got_pos,
                             logic [OUT_POS_W-1:0] got_len, logic got_last);
    payload_word_t want;
    if (payload_q.size() == 0) begin
      $error("unexpected payload word: payload_byte %0d, byte_position %0d",
             got_byte, got_pos);
      errors++;
      return;
    end
    want = payload_q.pop_front();
    compare_field("payload_byte", want.payload_byte, got_byte);
    compare_field("byte_position", 8'(want.byte_position), 8'(got_pos));
    compare_field("frame_length", 8'(want.frame_length), 8'(got_len));
    compare_field("last", 8'(want.last), 8'(got_last));
  endfunction
endclass

module testbench;

  localparam int QUIET_LIMIT   = 4000;
  localparam int HOLD_CYCLES   = 400;
  localparam int SETTLE_CYCLES = 4;

  typedef enum int {
    FLAW_NONE,
    FLAW_CRC,
    FLAW_END,
    FLAW_END_START,
    FLAW_LEN,
    FLAW_BYTE_GAP,
    FLAW_POLL_GAP,
    FLAW_OVERFLOW
  } frame_flaw_e;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_push = 1'b0;
  logic                 in_full;
  logic [1:0]           in_mode = 2'd0;
  logic [7:0]           in_data_byte = 8'd0;
  logic [TIME_W-1:0]    in_now_us = '0;
  logic                 out_empty;
  logic                 out_pop = 1'b0;
  logic [7:0]           out_payload_byte;
  logic [OUT_POS_W-1:0] out_byte_position;
  logic [OUT_POS_W-1:0] out_frame_length;
  logic                 out_last;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = 1'b0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  frame_scoreboard sb;
  logic [31:0]     cursor = 32'd0;
  int              items_sent = 0;
  int              send_idle_pct = 0;
  int              recv_idle_pct = 0;
  int              hold_request = 0;
  bit              resync_pending = 1'b0;

  packet_deframer_crc16 #(.MAX_PAYLOAD(MAX_LEN)) u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_mode           (in_mode),
    .in_data_byte      (in_data_byte),
    .in_now_us         (in_now_us),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_payload_byte  (out_payload_byte),
    .out_byte_position (out_byte_position),
    .out_frame_length  (out_frame_length),
    .out_last          (out_last),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Offers one word and returns at the edge that accepts it.
  task automatic send_item(logic [1:0] mode, logic [7:0] data, logic [31:0] stamp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_push <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_mode <= mode;
    in_data_byte <= data;
    in_now_us <= stamp;
    @(posedge clk);
    while (in_full) @(posedge clk);
    sb.note_input(mode, data, stamp);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  task automatic byte_at(logic [7:0] data, logic [31:0] delta);
    cursor = cursor + delta;
    send_item(MODE_BYTE, data, cursor);
  endtask

  function automatic logic [31:0] pick_gap();
    logic [31:0] lim;
    lim = sb.byte_gap_limit;
    if ($urandom_range(99) < 5) return lim;
    return $urandom_range((lim < 300) ? lim : 300, 0);
  endfunction

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return MAX_LEN;
    if (r < 20) return $urandom_range(MAX_LEN, 1);
    return $urandom_range(8, 1);
  endfunction

  task automatic send_frame(int len, frame_flaw_e flaw);
    logic [7:0]  pkt [$];
    logic [15:0] crc;
    logic [7:0]  tail;
    logic [31:0] gap;
    int          cut;
    crc = 16'h0000;
    // After a trailer that was a start byte, the parser already waits for a length.
    if (!resync_pending) pkt.push_back(START_BYTE);
    resync_pending = (flaw == FLAW_END_START);
    if (flaw == FLAW_LEN) begin
      pkt.push_back(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(255, MAX_LEN + 1)));
    end else begin
      pkt.push_back(8'(len));
    end
    for (int i = 0; i < len; i++) begin
      pkt.push_back(8'($urandom_range(255)));
      crc = sb.crc_step(crc, pkt[$]);
    end
    if (flaw == FLAW_CRC) crc = crc ^ (16'h0001 << $urandom_range(15));
    pkt.push_back(crc[15:8]);
    pkt.push_back(crc[7:0]);
    case (flaw)
      FLAW_END: begin
        do tail = 8'($urandom_range(255)); while (tail == END_BYTE || tail == START_BYTE);
        pkt.push_back(tail);
      end
      FLAW_END_START: pkt.push_back(START_BYTE);
      default: pkt.push_back(END_BYTE);
    endcase
    cut = $urandom_range(pkt.size() - 1, 1);
    foreach (pkt[i]) begin
      gap = pick_gap();
      if (i == cut) begin
        case (flaw)
          FLAW_BYTE_GAP: gap = sb.byte_gap_limit + $urandom_range(5000, 1);
          FLAW_POLL_GAP: send_item(MODE_POLL, 8'($urandom_range(255)),
                                   cursor + sb.poll_gap_limit + $urandom_range(5000, 1));
          FLAW_OVERFLOW: send_item(MODE_OVERFLOW, 8'($urandom_range(255)), cursor + gap);
          default: ;
        endcase
      end else if ($urandom_range(99) < 8) begin
        // A poll inside the limit must leave the frame alone.
        send_item(MODE_POLL, 8'($urandom_range(255)),
                  cursor + $urandom_range(sb.poll_gap_limit, 0));
      end
      if ($urandom_range(99) < 3) send_item(MODE_UNUSED, 8'($urandom_range(255)), $urandom());
      cursor = cursor + gap;
      send_item(MODE_BYTE, pkt[i], cursor);
    end
  endtask

  task automatic send_noise();
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(3))
        0: begin
          cursor = ($urandom_range(1) == 0) ? $urandom() : cursor + $urandom_range(100000, 0);
          send_item(MODE_BYTE, 8'($urandom_range(255)), cursor);
        end
        1: send_item(MODE_POLL, 8'($urandom_range(255)), $urandom());
        2: send_item(MODE_OVERFLOW, 8'($urandom_range(255)), $urandom());
        default: send_item(MODE_UNUSED, 8'($urandom_range(255)), $urandom());
      endcase
    end
  endtask

  task automatic run_random(int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        send_frame(pick_len(), FLAW_NONE);
      end else if (pick < 88) begin
        send_frame(pick_len(), frame_flaw_e'($urandom_range(int'(FLAW_OVERFLOW),
                                                            int'(FLAW_CRC))));
      end else begin
        send_noise();
      end
      if ($urandom_range(99) < 10) cursor = $urandom();
    end
  endtask

  // Lowers push and waits until the block has handed out every expected word.
  task automatic settle();
    in_push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_timeouts(logic [CFG_W-1:0] byte_us, logic [CFG_W-1:0] poll_us);
    settle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_BYTE_GAP;
    cfg_wdata <= byte_us;
    @(posedge clk);
    sb.set_timeout(CFG_BYTE_GAP, byte_us);
    cfg_index <= CFG_POLL_GAP;
    cfg_wdata <= poll_us;
    @(posedge clk);
    sb.set_timeout(CFG_POLL_GAP, poll_us);
    cfg_we <= 1'b0;
  endtask

  // Good frames keep coming while the reader holds off, so both banks fill and push stalls.
  task automatic fill_and_drain();
    int saved;
    saved = send_idle_pct;
    send_idle_pct = 0;
    hold_request = HOLD_CYCLES;
    send_frame(3, FLAW_NONE);
    send_frame(5, FLAW_NONE);
    send_frame(MAX_LEN, FLAW_NONE);
    send_frame(4, FLAW_NONE);
    send_frame(6, FLAW_NONE);
    send_idle_pct = saved;
    settle();
  endtask

  // Result side: checks each accepted word, then decides the next pop.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        sb.check_result(out_payload_byte, out_byte_position, out_frame_length, out_last);
      end
      if (hold_request > 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [15:0] crc_ff;
    logic [15:0] crc_00;
    sb = new();
    crc_ff = sb.crc_step(16'h0000, 8'hFF);
    crc_00 = sb.crc_step(16'h0000, 8'h00);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // One-byte frame across the timestamp wrap, with the timeouts at their reset values.
    cursor = 32'hFFFF_FFFD;
    byte_at(START_BYTE, 1);
    byte_at(8'd1, 1);
    byte_at(8'hFF, 1);
    byte_at(crc_ff[15:8], 1);
    byte_at(crc_ff[7:0], 1);
    byte_at(END_BYTE, 1);
    // Zero and oversized lengths.
    byte_at(START_BYTE, 5);
    byte_at(8'h00, 5);
    byte_at(START_BYTE, 5);
    byte_at(8'hFF, 5);
    // A gap right at the limit is kept, one past it drops the frame.
    byte_at(START_BYTE, 5);
    byte_at(8'd1, BYTE_GAP_RESET);
    byte_at(8'h00, BYTE_GAP_RESET + 1);
    byte_at(START_BYTE, 5);
    send_item(MODE_POLL, 8'hA5, cursor + POLL_GAP_RESET);
    send_item(MODE_POLL, 8'h5A, cursor + POLL_GAP_RESET + 1);
    byte_at(START_BYTE, 5);
    send_item(MODE_OVERFLOW, 8'hFF, cursor);
    send_item(MODE_UNUSED, 8'h00, 32'hFFFF_FFFF);
    // A start byte in place of the end byte begins the next frame.
    byte_at(START_BYTE, 5);
    byte_at(8'd1, 5);
    byte_at(8'h00, 5);
    byte_at(crc_00[15:8], 5);
    byte_at(crc_00[7:0], 5);
    byte_at(START_BYTE, 5);
    byte_at(8'd1, 5);
    byte_at(8'h00, 5);
    byte_at(crc_00[15:8], 5);
    byte_at(crc_00[7:0], 5);
    byte_at(END_BYTE, 5);

    send_idle_pct = 23;
    recv_idle_pct = 55;
    set_timeouts(CFG_W'($urandom_range(5000, 200)), CFG_W'($urandom_range(20000, 200)));
    fill_and_drain();
    run_random(25);
    set_timeouts(CFG_W'(0), CFG_W'(1000000));
    run_random(50);

    send_idle_pct = 55;
    recv_idle_pct = 23;
    set_timeouts(CFG_W'(1000000), CFG_W'(0));
    run_random(50);
    set_timeouts(CFG_W'($urandom_range(1000000)), CFG_W'($urandom_range(1000000)));
    run_random(50);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_timeouts(CFG_W'($urandom_range(2000)), CFG_W'($urandom_range(4000)));
    run_random(50);
    set_timeouts(CFG_W'($urandom_range(1000000)), CFG_W'($urandom_range(1000000)));
    run_random(50);
    settle();

    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/pdc_pkg.sv
hdl/pdc_front.sv
hdl/pdc_desc_fifo.sv
hdl/pdc_back.sv
hdl/packet_deframer_crc16.sv
hdl/pdc_checker.sv
verif/testbench.sv
